// ===== hdl/blocked_grid_path_counter_core_defines.svh =====
// Assertion macros for the blocked grid path counter.
// Included by the top level; no other dependencies.
`ifndef BLOCKED_GRID_PATH_COUNTER_CORE_DEFINES_SVH
`define BLOCKED_GRID_PATH_COUNTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BGPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgpc check failed");

// next-cycle implication
`define BGPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgpc check failed");

`endif

// ===== hdl/bgpc_pkg.sv =====
// Shared constants and types for the blocked grid path counter.
// No dependencies.
`timescale 1ns / 1ps

package bgpc_pkg;

    localparam int MAX_DIM = 64;
    localparam int SIDE    = MAX_DIM + 1;
    localparam int DIAGS   = 2 * MAX_DIM + 1;
    localparam int COORD_W = 7;
    localparam int ROW_W   = $clog2(SIDE);
    localparam int DIAG_W  = $clog2(DIAGS);
    localparam int CNT_W   = 64;

    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_COUNT = 1'b1;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic step_en;
        logic first_col;
        logic clear_ovf;
    } cell_ctl_t;

endpackage

// ===== hdl/blocked_grid_path_counter_core.sv =====
// Blocked grid path counter, top level: mark decode, diagonal sweep control and cell chain.
// Depends on bgpc_pkg, bgpc_map, bgpc_cell and blocked_grid_path_counter_core_defines.svh.
//
// Mark words are taken while idle and may follow back to back. A count word
// starts a skewed wavefront over a chain of 65 cells, one per grid row: the maps are
// read one anti-diagonal per cycle, from 0 to W+H (W, H the grid size clamped to 64),
// then the flush and done states follow and the result is offered from the output
// register, when both maps are cleared. No input word is taken during a count. A
// finished result waits in the output register without blocking the input; a later
// count holds its own result back until the waiting one has been taken.
`timescale 1ns / 1ps

`include "blocked_grid_path_counter_core_defines.svh"

module blocked_grid_path_counter_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [bgpc_pkg::COORD_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [bgpc_pkg::COORD_W-1:0] first_x,
    input  logic [bgpc_pkg::COORD_W-1:0] first_y,
    input  logic [bgpc_pkg::COORD_W-1:0] second_x,
    input  logic [bgpc_pkg::COORD_W-1:0] second_y,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bgpc_pkg::CNT_W-1:0]   path_count,
    output logic                        overflowed
);
    import bgpc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [COORD_W-1:0] grid_width_reg, grid_height_reg;
    logic [ROW_W-1:0]   wc_reg, wc_next, hc_reg, hc_next;
    logic [DIAG_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic               step_reg;
    logic [DIAG_W-1:0]  diag_reg;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   path_count_reg, path_count_next;
    logic               overflowed_reg, overflowed_next;

    logic               accept;
    logic               mark;
    logic               count_go;
    logic               done_fire;
    logic               sweep_re;
    logic               last_diag;
    logic [COORD_W-1:0] up_y, rt_x;
    logic               up_we, rt_we;
    logic [DIAG_W-1:0]  up_addr, rt_addr;
    logic [SIDE-1:0]    up_bits, rt_bits;

    cell_ctl_t          cell_ctl [SIDE];
    logic [CNT_W-1:0]   cnt [SIDE];
    logic [SIDE-1:0]    cell_ovf;

    assign accept   = in_valid && !in_stall;
    assign mark     = accept && (opcode == OP_MARK);
    assign count_go = accept && (opcode == OP_COUNT);
    assign in_stall = (state_reg != ST_IDLE);
    assign sweep_re = (state_reg == ST_SWEEP);
    assign last_diag = rd_cnt_reg == (DIAG_W'(wc_reg) + DIAG_W'(hc_reg));
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // mark decode
    always_comb
    begin
        up_y    = (first_y > second_y) ? first_y : second_y;
        rt_x    = (first_x > second_x) ? first_x : second_x;
        up_we   = mark && (first_x == second_x) && (second_x <= COORD_W'(MAX_DIM))
                  && (up_y <= COORD_W'(MAX_DIM));
        rt_we   = mark && (first_y == second_y) && (rt_x <= COORD_W'(MAX_DIM))
                  && (second_y <= COORD_W'(MAX_DIM));
        up_addr = DIAG_W'(second_x) + DIAG_W'(up_y);
        rt_addr = DIAG_W'(rt_x) + DIAG_W'(second_y);
    end

    bgpc_map u_up_map (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (up_we),
        .waddr (up_addr),
        .wbit  (up_y[ROW_W-1:0]),
        .re    (sweep_re),
        .raddr (rd_cnt_reg),
        .clear (done_fire),
        .rdata (up_bits)
    );

    bgpc_map u_rt_map (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (rt_we),
        .waddr (rt_addr),
        .wbit  (second_y[ROW_W-1:0]),
        .re    (sweep_re),
        .raddr (rd_cnt_reg),
        .clear (done_fire),
        .rdata (rt_bits)
    );

    // cell j works on column diag-j while that column lies inside the target grid
    always_comb
    begin
        for (int j = 0; j < SIDE; j++)
        begin
            cell_ctl[j].step_en   = step_reg && (diag_reg >= DIAG_W'(j))
                                    && ((diag_reg - DIAG_W'(j)) <= DIAG_W'(wc_reg))
                                    && (ROW_W'(j) <= hc_reg);
            cell_ctl[j].first_col = (diag_reg == DIAG_W'(j));
            cell_ctl[j].clear_ovf = step_reg && (diag_reg == '0);
        end
    end

    bgpc_cell u_cell_0 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cell_ctl[0]),
        .up    (1'b0),
        .rt    (rt_bits[0]),
        .below ({{(CNT_W-1){1'b0}}, (diag_reg == '0)}),
        .count (cnt[0]),
        .ovf   (cell_ovf[0])
    );

    for (genvar g = 1; g < SIDE; g++)
    begin : g_cell
        bgpc_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (cell_ctl[g]),
            .up    (up_bits[g]),
            .rt    (rt_bits[g]),
            .below (cnt[g-1]),
            .count (cnt[g]),
            .ovf   (cell_ovf[g])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        wc_next         = wc_reg;
        hc_next         = hc_reg;
        rd_cnt_next     = rd_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        path_count_next = path_count_reg;
        overflowed_next = overflowed_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (count_go)
                begin
                    wc_next     = (grid_width_reg > COORD_W'(MAX_DIM)) ? ROW_W'(MAX_DIM)
                                  : grid_width_reg[ROW_W-1:0];
                    hc_next     = (grid_height_reg > COORD_W'(MAX_DIM)) ? ROW_W'(MAX_DIM)
                                  : grid_height_reg[ROW_W-1:0];
                    rd_cnt_next = '0;
                    state_next  = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (last_diag)
                    state_next = ST_FLUSH;
                else
                    rd_cnt_next = rd_cnt_reg + 1'b1;
            end
            ST_FLUSH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    path_count_next = cnt[hc_reg];
                    overflowed_next = |cell_ovf;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wc_reg         <= '0;
            hc_reg         <= '0;
            rd_cnt_reg     <= '0;
            step_reg       <= 1'b0;
            diag_reg       <= '0;
            out_valid_reg  <= 1'b0;
            path_count_reg <= '0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wc_reg         <= wc_next;
            hc_reg         <= hc_next;
            rd_cnt_reg     <= rd_cnt_next;
            step_reg       <= sweep_re;
            diag_reg       <= rd_cnt_reg;
            out_valid_reg  <= out_valid_next;
            path_count_reg <= path_count_next;
            overflowed_reg <= overflowed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= '0;
            grid_height_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:         grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign path_count = path_count_reg;
    assign overflowed = overflowed_reg;

    `BGPC_ASSERT_NEXT(a_count_starts_sweep, count_go, state_reg == ST_SWEEP)
    `BGPC_ASSERT_NOW(a_result_from_done, $rose(out_valid_reg), $past(state_reg) == ST_DONE)
    `BGPC_ASSERT_NOW(a_diag_in_range, step_reg, diag_reg <= DIAG_W'(wc_reg) + DIAG_W'(hc_reg))

endmodule

// ===== hdl/bgpc_map.sv =====
// Street block map stored by anti-diagonal (row x+y, bit y), with per-row valid bits.
// Depends on bgpc_pkg.
`timescale 1ns / 1ps

module bgpc_map (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       we,
    input  logic [bgpc_pkg::DIAG_W-1:0] waddr,
    input  logic [bgpc_pkg::ROW_W-1:0]  wbit,
    input  logic                       re,
    input  logic [bgpc_pkg::DIAG_W-1:0] raddr,
    input  logic                       clear,
    output logic [bgpc_pkg::SIDE-1:0]   rdata
);
    import bgpc_pkg::*;

    logic [SIDE-1:0]  mem [DIAGS];
    logic [DIAGS-1:0] row_valid_reg;
    logic [SIDE-1:0]  rdata_reg;
    logic             rvalid_reg;
    logic [SIDE-1:0]  onehot;

    assign onehot = SIDE'(1) << wbit;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            if (row_valid_reg[waddr])
                mem[waddr][wbit] <= 1'b1;
            else
                mem[waddr] <= onehot;
        end
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            if (clear)
                row_valid_reg <= '0;
            else if (we)
                row_valid_reg[waddr] <= 1'b1;
            if (re)
                rvalid_reg <= row_valid_reg[raddr];
        end
    end

    // a row never written since the last clear reads as all clear
    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== hdl/bgpc_cell.sv =====
// One row of the wavefront: holds the running path count of its y and a sticky overflow.
// Depends on bgpc_pkg.
`timescale 1ns / 1ps

module bgpc_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bgpc_pkg::cell_ctl_t       ctl,
    input  logic                      up,
    input  logic                      rt,
    input  logic [bgpc_pkg::CNT_W-1:0] below,
    output logic [bgpc_pkg::CNT_W-1:0] count,
    output logic                      ovf
);
    import bgpc_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic [CNT_W-1:0] left;
    logic [CNT_W-1:0] from_below;
    logic [CNT_W-1:0] from_left;
    logic [CNT_W:0]   sum;

    always_comb
    begin
        left       = ctl.first_col ? '0 : count_reg;
        from_below = up ? '0 : below;
        from_left  = rt ? '0 : left;
        sum        = {1'b0, from_below} + {1'b0, from_left};
        count_next = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step_en)
            count_reg <= count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovf_reg <= 1'b0;
        else if (ctl.clear_ovf && !ctl.step_en)
            ovf_reg <= 1'b0;
        else if (ctl.step_en)
            ovf_reg <= sum[CNT_W] || (ovf_reg && !ctl.clear_ovf);
    end

    assign count = count_reg;
    assign ovf   = ovf_reg;

endmodule
